>>> rtl/core/psp_pkg.sv
// Package for the polygon plane splitter: shared types, codes and constants.
// Used by every module under rtl/core except psp_ram; depends on nothing.
`default_nettype none
package psp_pkg;

  localparam int MAX_VERTS = 16;
  localparam int CNT_W     = $clog2(MAX_VERTS + 1);
  localparam int IDX_W     = $clog2(MAX_VERTS);
  localparam int LCNT_W    = $clog2(2 * MAX_VERTS + 1);
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_D   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd4;

  localparam logic signed [31:0] ONE_Q30     = 32'sh4000_0000;
  localparam logic signed [31:0] NEG_ONE_Q30 = -32'sh4000_0000;
  localparam logic signed [31:0] SAT_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN     = 32'sh8000_0000;

  localparam logic [1:0] SIDE_F = 2'd0;
  localparam logic [1:0] SIDE_B = 2'd1;
  localparam logic [1:0] SIDE_O = 2'd2;

  localparam logic [1:0] JOB_ERR_IN   = 2'd0;
  localparam logic [1:0] JOB_ERR_LIST = 2'd1;
  localparam logic [1:0] JOB_COPY     = 2'd2;
  localparam logic [1:0] JOB_WALK     = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_IN_OVF   = 2'd1;
  localparam logic [1:0] ST_LIST_OVF = 2'd2;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic               final_vertex;
  } in_item_t;

  typedef struct packed {
    logic               dest_side;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               is_split;
    logic               run_end;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] sdist;
    logic [1:0]         side;
  } ent_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic             copy_side;
    logic [CNT_W-1:0] n;
  } job_t;

  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic signed [31:0] pd;
    logic [15:0]        tol;
  } cfg_t;

  function automatic logic crosses(input logic [1:0] a, input logic [1:0] b);
    crosses = (a != SIDE_O) && (b != SIDE_O) && (a != b);
  endfunction

  function automatic logic signed [31:0] clamp_q30(input logic [31:0] v);
    logic signed [31:0] s;
    s = $signed(v);
    if (s > ONE_Q30) clamp_q30 = ONE_Q30;
    else if (s < NEG_ONE_Q30) clamp_q30 = NEG_ONE_Q30;
    else clamp_q30 = s;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/polygon_plane_split_top.sv
// Top level of the polygon plane splitter: front end, job queue, vertex RAM
// and emitter. Depends on psp_pkg, psp_front, psp_jobq, psp_ram, psp_back.
//
//   channel  ports                                   transaction
//   input    start, busy, in_data                    start && !busy
//   result   out_valid, out_data                     out_valid, one cycle
//   config   cfg_we, cfg_index, cfg_wdata            cfg_we
//
// A vertex holds the front end from accept to accept: 4 multiply-accumulate
// steps, round, distance and side, done; one past MAX_VERTS goes straight to
// done. The final vertex queues a job; the emitter loads the first vertex, then
// per vertex fetches, loads, emits (twice if on-plane) and advances, plus, per
// split, a 65-step divide per coordinate (none for a unit normal) and 2 results.
// busy holds meanwhile; the receiver cannot stall. rst_n is sync.
`default_nettype none
module polygon_plane_split_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire psp_pkg::in_item_t             in_data,
  output logic                               out_valid,
  output psp_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_we,
  input  wire logic [psp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_wdata
);
  psp_pkg::cfg_t cfg;
  psp_pkg::job_t job_in, job_out;
  psp_pkg::ent_t wr_data, rd_data;
  logic [psp_pkg::IDX_W-1:0] wr_addr, rd_addr;
  logic front_busy, back_busy, wr_en, job_push, q_valid, pop;
  logic accept;

  assign busy = front_busy || q_valid || back_busy;
  assign accept = start && !busy;

  psp_front u_front (
    .clk, .rst_n, .accept, .in_data, .cfg_we, .cfg_index, .cfg_wdata,
    .cfg, .front_busy, .wr_en, .wr_addr, .wr_data, .job_push, .job(job_in)
  );

  psp_jobq u_jobq (
    .clk, .rst_n, .push(job_push), .job_in, .pop, .valid(q_valid), .job_out
  );

  psp_ram #(.W($bits(psp_pkg::ent_t)), .D(psp_pkg::MAX_VERTS)) u_ram (
    .clk, .we(wr_en), .waddr(wr_addr), .wdata(wr_data), .raddr(rd_addr), .rdata(rd_data)
  );

  psp_back u_back (
    .clk, .rst_n, .q_valid, .job(job_out), .pop, .cfg, .rd_addr, .rd_data,
    .back_busy, .out_valid, .out_data
  );
endmodule
`default_nettype wire

>>> rtl/core/psp_ram.sv
// Generic single write, single registered read RAM.
// Standalone; no package dependency.
`default_nettype none
module psp_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

>>> rtl/core/psp_front.sv
// Front end: configuration registers, per-vertex plane distance and side,
// polygon bookkeeping and job creation. Depends on psp_pkg.
`default_nettype none
module psp_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            accept,
  input  wire psp_pkg::in_item_t               in_data,
  input  wire logic                            cfg_we,
  input  wire logic [psp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [31:0]                     cfg_wdata,
  output psp_pkg::cfg_t                        cfg,
  output logic                                 front_busy,
  output logic                                 wr_en,
  output logic [psp_pkg::IDX_W-1:0]            wr_addr,
  output psp_pkg::ent_t                        wr_data,
  output logic                                 job_push,
  output psp_pkg::job_t                        job
);
  typedef enum logic [2:0] {F_IDLE, F_MUL, F_RND, F_DIST, F_DONE} fstate_t;

  fstate_t state_r;
  psp_pkg::cfg_t cfg_r;
  logic signed [31:0] vx_r, vy_r, vz_r;
  logic fin_r;
  logic [1:0] mk_r;
  logic signed [63:0] prod_r;
  logic signed [65:0] acc_r;
  logic signed [35:0] rnd_r;
  logic [psp_pkg::CNT_W-1:0] vcnt_r, fcnt_r, bcnt_r, cross_r;
  logic ovf_r;
  logic [1:0] prev_side_r, first_side_r;

  logic signed [31:0] ma, mb;
  logic signed [65:0] rsum;
  logic signed [36:0] dd;
  logic signed [31:0] sdist;
  logic signed [32:0] d33, tol33;
  logic [1:0] side;
  logic [psp_pkg::LCNT_W-1:0] cr_tot, fl, bl, lim;
  logic list_bad;

  always_comb begin
    case (mk_r)
      2'd0:    begin ma = vx_r; mb = cfg_r.nx; end
      2'd1:    begin ma = vy_r; mb = cfg_r.ny; end
      default: begin ma = vz_r; mb = cfg_r.nz; end
    endcase
    rsum = acc_r + 66'sd536870912;
    dd = 37'(rnd_r) - 37'(cfg_r.pd);
    if (dd > 37'(psp_pkg::SAT_MAX)) sdist = psp_pkg::SAT_MAX;
    else if (dd < 37'(psp_pkg::SAT_MIN)) sdist = psp_pkg::SAT_MIN;
    else sdist = dd[31:0];
    d33 = 33'(sdist);
    tol33 = $signed({17'b0, cfg_r.tol});
    if (d33 > tol33) side = psp_pkg::SIDE_F;
    else if (d33 < -tol33) side = psp_pkg::SIDE_B;
    else side = psp_pkg::SIDE_O;
    cr_tot = psp_pkg::LCNT_W'(cross_r)
           + psp_pkg::LCNT_W'(psp_pkg::crosses(prev_side_r, first_side_r));
    fl = psp_pkg::LCNT_W'(vcnt_r) - psp_pkg::LCNT_W'(bcnt_r) + cr_tot;
    bl = psp_pkg::LCNT_W'(vcnt_r) - psp_pkg::LCNT_W'(fcnt_r) + cr_tot;
    lim = psp_pkg::LCNT_W'(vcnt_r) + psp_pkg::LCNT_W'(4);
    list_bad = (fl > psp_pkg::LCNT_W'(psp_pkg::MAX_VERTS))
            || (bl > psp_pkg::LCNT_W'(psp_pkg::MAX_VERTS))
            || (fl > lim) || (bl > lim);
    job.n = vcnt_r;
    job.copy_side = (fcnt_r == '0);
    if (ovf_r) job.mode = psp_pkg::JOB_ERR_IN;
    else if (fcnt_r == '0 || bcnt_r == '0) job.mode = psp_pkg::JOB_COPY;
    else if (list_bad) job.mode = psp_pkg::JOB_ERR_LIST;
    else job.mode = psp_pkg::JOB_WALK;
  end

  assign cfg = cfg_r;
  assign front_busy = (state_r != F_IDLE);
  assign wr_en = (state_r == F_DIST);
  assign wr_addr = vcnt_r[psp_pkg::IDX_W-1:0];
  assign wr_data = '{x: vx_r, y: vy_r, z: vz_r, sdist: sdist, side: side};
  assign job_push = (state_r == F_DONE) && fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cfg_r <= '{nx: 32'sd0, ny: 32'sd0, nz: psp_pkg::ONE_Q30, pd: 32'sd0, tol: 16'd26};
      vcnt_r <= '0;
      fcnt_r <= '0;
      bcnt_r <= '0;
      cross_r <= '0;
      ovf_r <= 1'b0;
      mk_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          psp_pkg::REG_NORMAL_X:  cfg_r.nx <= psp_pkg::clamp_q30(cfg_wdata);
          psp_pkg::REG_NORMAL_Y:  cfg_r.ny <= psp_pkg::clamp_q30(cfg_wdata);
          psp_pkg::REG_NORMAL_Z:  cfg_r.nz <= psp_pkg::clamp_q30(cfg_wdata);
          psp_pkg::REG_PLANE_D:   cfg_r.pd <= $signed(cfg_wdata);
          psp_pkg::REG_TOLERANCE: cfg_r.tol <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      case (state_r)
        F_IDLE: begin
          if (accept) begin
            vx_r <= in_data.vertex_x;
            vy_r <= in_data.vertex_y;
            vz_r <= in_data.vertex_z;
            fin_r <= in_data.final_vertex;
            mk_r <= '0;
            if (vcnt_r < psp_pkg::CNT_W'(psp_pkg::MAX_VERTS)) begin
              state_r <= F_MUL;
            end else begin
              ovf_r <= 1'b1;
              state_r <= F_DONE;
            end
          end
        end
        F_MUL: begin
          prod_r <= ma * mb;
          acc_r <= (mk_r == 2'd0) ? 66'sd0 : acc_r + 66'(prod_r);
          mk_r <= mk_r + 2'd1;
          if (mk_r == 2'd3) state_r <= F_RND;
        end
        F_RND: begin
          rnd_r <= rsum[65:30];
          state_r <= F_DIST;
        end
        F_DIST: begin
          vcnt_r <= vcnt_r + psp_pkg::CNT_W'(1);
          if (side == psp_pkg::SIDE_F) fcnt_r <= fcnt_r + psp_pkg::CNT_W'(1);
          if (side == psp_pkg::SIDE_B) bcnt_r <= bcnt_r + psp_pkg::CNT_W'(1);
          if (vcnt_r == '0) first_side_r <= side;
          else if (psp_pkg::crosses(prev_side_r, side))
            cross_r <= cross_r + psp_pkg::CNT_W'(1);
          prev_side_r <= side;
          state_r <= F_DONE;
        end
        F_DONE: begin
          if (fin_r) begin
            vcnt_r <= '0;
            fcnt_r <= '0;
            bcnt_r <= '0;
            cross_r <= '0;
            ovf_r <= 1'b0;
          end
          state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/psp_jobq.sv
// Two-entry job queue between the front end and the emitter.
// Depends on psp_pkg.
`default_nettype none
module psp_jobq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire psp_pkg::job_t  job_in,
  input  wire logic           pop,
  output logic                valid,
  output psp_pkg::job_t       job_out
);
  psp_pkg::job_t q_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign valid = (cnt_r != 2'd0);
  assign job_out = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && cnt_r != 2'd2) begin
        q_r[wp_r] <= job_in;
        wp_r <= ~wp_r;
      end
      if (pop && valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'((push && cnt_r != 2'd2) ? 1 : 0) - 2'((pop && valid) ? 1 : 0);
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/psp_back.sv
// Emitter: walks the stored polygon, computes split points with a serial
// divider and drives the result strobe. Depends on psp_pkg.
`default_nettype none
module psp_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_valid,
  input  wire psp_pkg::job_t              job,
  output logic                            pop,
  input  wire psp_pkg::cfg_t              cfg,
  output logic [psp_pkg::IDX_W-1:0]       rd_addr,
  input  wire psp_pkg::ent_t              rd_data,
  output logic                            back_busy,
  output logic                            out_valid,
  output psp_pkg::out_item_t              out_data
);
  typedef enum logic [3:0] {
    B_IDLE, B_ERR, B_LD0, B_FETCH, B_LDN, B_EMIT, B_ADV,
    B_SMUL, B_SDIV0, B_SDIV, B_SADD, B_EMS
  } bstate_t;

  bstate_t state_r;
  psp_pkg::job_t job_r;
  psp_pkg::ent_t cur_r, nxt_r, first_r;
  logic [psp_pkg::IDX_W-1:0] i_r;
  logic ph_r;
  logic [1:0] j_r;
  logic signed [31:0] mid_r [3];
  logic signed [64:0] prod_r;
  logic [64:0] num_r;
  logic [32:0] den_r, rem_r;
  logic neg_r;
  logic [6:0] k_r;
  logic out_valid_r;
  psp_pkg::out_item_t out_r;

  logic [psp_pkg::CNT_W-1:0] i_plus;
  logic is_last, has_next, cross_n;
  logic signed [31:0] ca, cb, cn;
  logic signed [32:0] dif, dden;
  logic [33:0] rsh;
  logic ge;
  logic signed [33:0] qs, msum;
  logic signed [31:0] neg_pd;

  always_comb begin
    i_plus = psp_pkg::CNT_W'(i_r) + psp_pkg::CNT_W'(1);
    is_last = (i_plus == job_r.n);
    has_next = (i_plus < job_r.n);
    cross_n = psp_pkg::crosses(cur_r.side, nxt_r.side);
    case (j_r)
      2'd0:    begin ca = cur_r.x; cb = nxt_r.x; cn = cfg.nx; end
      2'd1:    begin ca = cur_r.y; cb = nxt_r.y; cn = cfg.ny; end
      default: begin ca = cur_r.z; cb = nxt_r.z; cn = cfg.nz; end
    endcase
    dif = 33'(cb) - 33'(ca);
    dden = 33'(cur_r.sdist) - 33'(nxt_r.sdist);
    rsh = {rem_r, num_r[64]};
    ge = (rsh >= {1'b0, den_r});
    qs = neg_r ? -34'(num_r[32:0]) : 34'(num_r[32:0]);
    msum = 34'(ca) + qs;
    neg_pd = (cfg.pd == psp_pkg::SAT_MIN) ? psp_pkg::SAT_MAX : -cfg.pd;
    case (state_r)
      B_FETCH: rd_addr = i_plus[psp_pkg::IDX_W-1:0];
      default: rd_addr = '0;
    endcase
  end

  assign pop = (state_r == B_IDLE) && q_valid;
  assign back_busy = (state_r != B_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            job_r <= job;
            if (job.mode == psp_pkg::JOB_ERR_IN || job.mode == psp_pkg::JOB_ERR_LIST)
              state_r <= B_ERR;
            else
              state_r <= B_LD0;
          end
        end
        B_ERR: begin
          out_valid_r <= 1'b1;
          out_r <= '{dest_side: 1'b0, out_x: 32'sd0, out_y: 32'sd0, out_z: 32'sd0,
                     is_split: 1'b0, run_end: 1'b1,
                     status: (job_r.mode == psp_pkg::JOB_ERR_IN) ?
                             psp_pkg::ST_IN_OVF : psp_pkg::ST_LIST_OVF};
          state_r <= B_IDLE;
        end
        B_LD0: begin
          cur_r <= rd_data;
          first_r <= rd_data;
          i_r <= '0;
          state_r <= B_FETCH;
        end
        B_FETCH: begin
          ph_r <= 1'b0;
          if (has_next) begin
            state_r <= B_LDN;
          end else begin
            nxt_r <= first_r;
            state_r <= B_EMIT;
          end
        end
        B_LDN: begin
          nxt_r <= rd_data;
          state_r <= B_EMIT;
        end
        B_EMIT: begin
          out_valid_r <= 1'b1;
          out_r.out_x <= cur_r.x;
          out_r.out_y <= cur_r.y;
          out_r.out_z <= cur_r.z;
          out_r.is_split <= 1'b0;
          out_r.status <= psp_pkg::ST_OK;
          if (job_r.mode == psp_pkg::JOB_COPY) begin
            out_r.dest_side <= job_r.copy_side;
            out_r.run_end <= is_last;
            state_r <= B_ADV;
          end else if (cur_r.side == psp_pkg::SIDE_O) begin
            out_r.dest_side <= ph_r;
            out_r.run_end <= ph_r && is_last;
            ph_r <= 1'b1;
            if (ph_r) state_r <= B_ADV;
          end else begin
            out_r.dest_side <= (cur_r.side == psp_pkg::SIDE_B);
            out_r.run_end <= is_last && !cross_n;
            j_r <= 2'd0;
            state_r <= cross_n ? B_SMUL : B_ADV;
          end
        end
        B_ADV: begin
          if (is_last) begin
            state_r <= B_IDLE;
          end else begin
            cur_r <= nxt_r;
            i_r <= i_r + psp_pkg::IDX_W'(1);
            state_r <= B_FETCH;
          end
        end
        B_SMUL: begin
          if (cn == psp_pkg::ONE_Q30 || cn == psp_pkg::NEG_ONE_Q30) begin
            mid_r[j_r] <= (cn == psp_pkg::ONE_Q30) ? cfg.pd : neg_pd;
            j_r <= j_r + 2'd1;
            if (j_r == 2'd2) begin
              ph_r <= 1'b0;
              state_r <= B_EMS;
            end
          end else begin
            prod_r <= 65'(cur_r.sdist) * 65'(dif);
            state_r <= B_SDIV0;
          end
        end
        B_SDIV0: begin
          num_r <= prod_r[64] ? 65'(-prod_r) : 65'(prod_r);
          den_r <= dden[32] ? 33'(-dden) : 33'(dden);
          neg_r <= prod_r[64] ^ dden[32];
          rem_r <= '0;
          k_r <= '0;
          state_r <= B_SDIV;
        end
        B_SDIV: begin
          rem_r <= ge ? 33'(rsh - {1'b0, den_r}) : rsh[32:0];
          num_r <= {num_r[63:0], ge};
          k_r <= k_r + 7'd1;
          if (k_r == 7'd64) state_r <= B_SADD;
        end
        B_SADD: begin
          mid_r[j_r] <= msum[31:0];
          j_r <= j_r + 2'd1;
          if (j_r == 2'd2) begin
            ph_r <= 1'b0;
            state_r <= B_EMS;
          end else begin
            state_r <= B_SMUL;
          end
        end
        B_EMS: begin
          out_valid_r <= 1'b1;
          out_r <= '{dest_side: ph_r, out_x: mid_r[0], out_y: mid_r[1], out_z: mid_r[2],
                     is_split: 1'b1, run_end: ph_r && is_last, status: psp_pkg::ST_OK};
          ph_r <= 1'b1;
          if (ph_r) state_r <= B_ADV;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> tb/tb_polygon_plane_split_top.sv
// Testbench for polygon_plane_split_top: drives polygons vertex by vertex, predicts
// the split front/back lists in SystemVerilog and checks every emitted result.
// Depends on psp_pkg and the RTL under rtl/core.
`default_nettype none
module tb_polygon_plane_split_top;
  import psp_pkg::*;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_data;
  logic out_valid;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_wdata;

  polygon_plane_split_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // plane state of the predictor
  longint pn_x, pn_y, pn_z, pl_d, tol;
  longint vx[MAX_VERTS], vy[MAX_VERTS], vz[MAX_VERTS], vd[MAX_VERTS];
  logic [1:0] vside[MAX_VERTS];
  int nverts, nfront, nback;
  bit lost_vertex;

  in_item_t pending_vertices[$];
  out_item_t expected_results[$];
  int errors;
  int idle_pct;
  longint cycles;
  bit cfg_phase;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint floor_q30(longint s);
    if (s >= 0) return s >>> 30;
    return -((-s + 64'sd1073741823) >>> 30);
  endfunction

  task automatic emit(bit side, longint x, longint y, longint z, bit split);
    out_item_t r;
    r = '0;
    r.dest_side = side;
    r.out_x = x[31:0];
    r.out_y = y[31:0];
    r.out_z = z[31:0];
    r.is_split = split;
    r.status = ST_OK;
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic emit_error(logic [1:0] code);
    out_item_t r;
    r = '0;
    r.run_end = 1'b1;
    r.status = code;
    expected_results.insert(expected_results.size(), r);
  endtask

  function automatic longint crossing(longint a, longint b, longint d1, longint d2,
                                      longint nc);
    if (nc == ONE_Q30) return pl_d;
    if (nc == -longint'(ONE_Q30)) return sat32(-pl_d);
    return a + (d1 * (b - a)) / (d1 - d2);
  endfunction

  task automatic split_walk(bit do_emit, output int fl, output int bl);
    int j;
    logic [1:0] s, sn;
    fl = 0;
    bl = 0;
    for (int i = 0; i < nverts; i++) begin
      j = (i + 1 < nverts) ? i + 1 : 0;
      s = vside[i];
      sn = vside[j];
      if (s == SIDE_O) begin
        if (do_emit) begin
          emit(1'b0, vx[i], vy[i], vz[i], 1'b0);
          emit(1'b1, vx[i], vy[i], vz[i], 1'b0);
        end
        fl++;
        bl++;
      end else begin
        if (do_emit) emit(s == SIDE_B, vx[i], vy[i], vz[i], 1'b0);
        if (s == SIDE_F) fl++;
        else bl++;
        if (sn != SIDE_O && sn != s) begin
          if (do_emit) begin
            emit(1'b0, crossing(vx[i], vx[j], vd[i], vd[j], pn_x),
                 crossing(vy[i], vy[j], vd[i], vd[j], pn_y),
                 crossing(vz[i], vz[j], vd[i], vd[j], pn_z), 1'b1);
            emit(1'b1, crossing(vx[i], vx[j], vd[i], vd[j], pn_x),
                 crossing(vy[i], vy[j], vd[i], vd[j], pn_y),
                 crossing(vz[i], vz[j], vd[i], vd[j], pn_z), 1'b1);
          end
          fl++;
          bl++;
        end
      end
    end
  endtask

  task automatic predict_vertex(in_item_t it);
    longint x, y, z, d;
    int fl, bl;
    x = longint'(it.vertex_x);
    y = longint'(it.vertex_y);
    z = longint'(it.vertex_z);
    if (nverts < MAX_VERTS) begin
      d = sat32(floor_q30(x * pn_x + y * pn_y + z * pn_z + 64'sd536870912) - pl_d);
      vx[nverts] = x;
      vy[nverts] = y;
      vz[nverts] = z;
      vd[nverts] = d;
      if (d > tol) begin
        vside[nverts] = SIDE_F;
        nfront++;
      end else if (d < -tol) begin
        vside[nverts] = SIDE_B;
        nback++;
      end else begin
        vside[nverts] = SIDE_O;
      end
      nverts++;
    end else begin
      lost_vertex = 1'b1;
    end
    if (!it.final_vertex) return;
    if (lost_vertex) begin
      emit_error(ST_IN_OVF);
    end else if (nfront == 0 || nback == 0) begin
      for (int i = 0; i < nverts; i++) emit(nfront == 0, vx[i], vy[i], vz[i], 1'b0);
      expected_results[$].run_end = 1'b1;
    end else begin
      split_walk(1'b0, fl, bl);
      if (fl > MAX_VERTS || bl > MAX_VERTS || fl > nverts + 4 || bl > nverts + 4)
        emit_error(ST_LIST_OVF);
      else begin
        split_walk(1'b1, fl, bl);
        expected_results[$].run_end = 1'b1;
      end
    end
    nverts = 0;
    nfront = 0;
    nback = 0;
    lost_vertex = 1'b0;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n || cfg_phase) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      predict_vertex(in_data);
      void'(pending_vertices.pop_front());
      if (pending_vertices.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_data <= pending_vertices[0];
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_vertices.size() > 0 &&
                 $urandom_range(99) >= idle_pct) begin
      start <= 1'b1;
      in_data <= pending_vertices[0];
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        if (out_data !== expected_results[0]) begin
          $display("%0t: mismatch expected %p actual %p", $time, expected_results[0],
                   out_data);
          errors++;
        end
        void'(expected_results.pop_front());
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (cycles > 64'd2000000) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [31:0] clamp_cfg(logic [31:0] v);
    longint s;
    s = longint'($signed(v));
    if (s > ONE_Q30) return ONE_Q30;
    if (s < -longint'(ONE_Q30)) return NEG_ONE_Q30;
    return v;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_NORMAL_X: pn_x = longint'($signed(clamp_cfg(val)));
      REG_NORMAL_Y: pn_y = longint'($signed(clamp_cfg(val)));
      REG_NORMAL_Z: pn_z = longint'($signed(clamp_cfg(val)));
      REG_PLANE_D: pl_d = longint'($signed(val));
      REG_TOLERANCE: tol = longint'(val[15:0]);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                           logic [31:0] d, logic [31:0] t);
    write_reg(REG_NORMAL_X, nx);
    write_reg(REG_NORMAL_Y, ny);
    write_reg(REG_NORMAL_Z, nz);
    write_reg(REG_PLANE_D, d);
    write_reg(REG_TOLERANCE, t);
  endtask

  task automatic drain();
    cfg_phase = 1'b0;
    while (pending_vertices.size() > 0 || start || busy || expected_results.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_phase = 1'b1;
    @(posedge clk);
  endtask

  task automatic add_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit fin);
    in_item_t it;
    it.vertex_x = x;
    it.vertex_y = y;
    it.vertex_z = z;
    it.final_vertex = fin;
    pending_vertices.insert(pending_vertices.size(), it);
  endtask

  function automatic logic [31:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8000)) - 4000);
      default: return 32'($signed($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  task automatic add_polygon(int nv, int mode);
    for (int i = 0; i < nv; i++)
      add_vertex(rnd_coord(mode), rnd_coord(mode), rnd_coord(mode), i == nv - 1);
  endtask

  initial begin
    int sent, nv;
    errors = 0;
    cycles = 0;
    idle_pct = 23;
    cfg_phase = 1'b1;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    pn_x = 0;
    pn_y = 0;
    pn_z = ONE_Q30;
    pl_d = 0;
    tol = 26;
    nverts = 0;
    nfront = 0;
    nback = 0;
    lost_vertex = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset plane z = 0: crossing, all-on, all-back, extremes, input overflow
    add_vertex(32'sh100, 32'sh0, 32'sh1000, 1'b0);
    add_vertex(32'sh200, 32'sh100, -32'sh1000, 1'b0);
    add_vertex(32'sh7FFFFFFF, 32'sh80000000, 32'sh0, 1'b1);
    add_vertex(32'sh1, 32'sh2, 32'sh5, 1'b0);
    add_vertex(32'sh80000000, 32'sh7FFFFFFF, -32'sh5, 1'b1);
    add_vertex(32'sh0, 32'sh0, 32'sh80000000, 1'b0);
    add_vertex(32'shFFFFFFFF, 32'sh0, 32'sh80000000, 1'b1);
    for (int i = 0; i < MAX_VERTS + 2; i++) add_vertex(i, i, i * 64, i == MAX_VERTS + 1);
    drain();

    // oblique plane, wide tolerance, register index beyond the list
    set_plane(32'sh2D413CCD, 32'shD2BEC333, 32'sh80000000, 32'sh7FFFFFFF, 32'hFFFF);
    write_reg(3'd7, 32'hDEADBEEF);
    add_polygon(4, 0);
    add_polygon(3, 2);
    for (int i = 0; i < 8; i++)
      add_vertex((i & 1) ? 32'sh100000 : -32'sh100000, 32'sh0, 32'sh0, i == 7);
    drain();

    set_plane(32'sh7FFFFFFF, 32'sh0, 32'sh0, 32'sh80000000, 32'h0);
    add_polygon(5, 0);
    drain();

    sent = 0;
    while (sent < 280) begin
      case (sent % 150 < 40 ? 3 : $urandom_range(0, 2))
        0: set_plane($urandom_range(0, 1) ? ONE_Q30 : NEG_ONE_Q30,
                     32'($signed($urandom_range(0, 32'h7FFFFFFF)) - 32'sh40000000),
                     $urandom(), $urandom(), $urandom_range(0, 2000));
        1: set_plane(32'($signed($urandom_range(0, 32'h7FFFFFFF)) - 32'sh40000000),
                     32'($signed($urandom_range(0, 32'h7FFFFFFF)) - 32'sh40000000),
                     32'($signed($urandom_range(0, 32'h7FFFFFFF)) - 32'sh40000000),
                     32'($signed($urandom_range(0, 4000)) - 2000), $urandom_range(0, 300));
        default: set_plane(32'sh0, 32'sh0, 32'sh0, $urandom_range(0, 1) ? 32'sh0 : 32'sh1,
                           $urandom());
      endcase
      idle_pct = (sent % 150 < 40) ? 0 : 23;
      for (int p = 0; p < 6; p++) begin
        nv = ($urandom_range(0, 19) == 0) ? $urandom_range(MAX_VERTS, MAX_VERTS + 3)
                                         : $urandom_range(3, 8);
        add_polygon(nv, $urandom_range(0, 2));
        sent += nv;
      end
      drain();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> sim.f
rtl/core/psp_pkg.sv
rtl/core/psp_ram.sv
rtl/core/psp_front.sv
rtl/core/psp_jobq.sv
rtl/core/psp_back.sv
rtl/core/polygon_plane_split_top.sv
tb/tb_polygon_plane_split_top.sv
